[sv/sync_framed_packet_deframer_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sync-framed packet deframer
// Concurrent checks that can be compiled out by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAMED_PACKET_DEFRAMER_TOP_MACROS_SVH
`define SYNC_FRAMED_PACKET_DEFRAMER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside of reset
`define SFPD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included
`define SFPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFPD_ASSERT(lbl, clk, rst, prop, msg)
`define SFPD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[sv/sfpd_pkg.sv]
// ----------------------------------------------------------------------------
// Sync-framed packet deframer package
// Parse phases, result codes, register map and the bundles between modules.
// ----------------------------------------------------------------------------
package sfpd_pkg;

   // Parse phase, one-hot
   typedef enum logic [6:0] {
      PH_SYNC1 = 7'b0000001,
      PH_SYNC2 = 7'b0000010,
      PH_DESC  = 7'b0000100,
      PH_LEN   = 7'b0001000,
      PH_DATA  = 7'b0010000,
      PH_CHK1  = 7'b0100000,
      PH_CHK2  = 7'b1000000
   } sfpd_phase_type;

   // Result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_GOOD    = 2'd1;
   localparam logic [1:0] KIND_BAD     = 2'd2;

   // Register map
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic REG_SYNC_FIRST  = 1'b0;
   localparam logic REG_SYNC_SECOND = 1'b1;

   localparam logic [7:0] SYNC_FIRST_RESET  = 8'd117;
   localparam logic [7:0] SYNC_SECOND_RESET = 8'd101;

   // Sync byte settings handed to the parser
   typedef struct packed {
      logic [7:0] sync_first;
      logic [7:0] sync_second;
   } sfpd_cfg_type;

   // One result transaction
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] descriptor;
      logic [7:0] payload_byte;
      logic [7:0] byte_index;
      logic [7:0] payload_length;
   } sfpd_result_type;

endpackage

[sv/sfpd_parser.sv]
// ----------------------------------------------------------------------------
// Packet parser
// Phase tracking, Fletcher-style sums and result formation for one byte.
// ----------------------------------------------------------------------------
module sfpd_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     byte_accept,
   input  logic [7:0]               rx_byte,
   input  sfpd_pkg::sfpd_cfg_type   cfg,
   output logic                     res_valid,
   output sfpd_pkg::sfpd_result_type res
);
   import sfpd_pkg::*;

   `include "sync_framed_packet_deframer_top_macros.svh"

   sfpd_phase_type phase_ff, phase_in;
   logic [7:0] desc_ff, desc_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] sum_a_ff, sum_a_in;
   logic [7:0] sum_b_ff, sum_b_in;
   logic [7:0] chk1_ff, chk1_in;

   logic [7:0] acc_a;
   logic [7:0] acc_b;
   logic [7:0] count_next;
   logic       good;

   // Running sums with this byte folded in
   assign acc_a      = sum_a_ff + rx_byte;
   assign acc_b      = sum_b_ff + acc_a;
   assign count_next = count_ff + 8'd1;
   assign good       = (chk1_ff == sum_a_ff) && (rx_byte == sum_b_ff);

   // Advance the phase and form at most one result
   always_comb begin
      phase_in  = phase_ff;
      desc_in   = desc_ff;
      len_in    = len_ff;
      count_in  = count_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      chk1_in   = chk1_ff;
      res_valid = 1'b0;
      res.kind           = KIND_PAYLOAD;
      res.descriptor     = desc_ff;
      res.payload_byte   = 8'd0;
      res.byte_index     = 8'd0;
      res.payload_length = len_ff;
      unique case (phase_ff)
         PH_SYNC2: begin
            if (rx_byte == cfg.sync_second) begin
               sum_a_in = acc_a;
               sum_b_in = acc_b;
               phase_in = PH_DESC;
            end else begin
               phase_in = PH_SYNC1;
            end
         end
         PH_DESC: begin
            desc_in  = rx_byte;
            sum_a_in = acc_a;
            sum_b_in = acc_b;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            len_in   = rx_byte;
            sum_a_in = acc_a;
            sum_b_in = acc_b;
            count_in = 8'd0;
            phase_in = (rx_byte == 8'd0) ? PH_CHK1 : PH_DATA;
         end
         PH_DATA: begin
            sum_a_in         = acc_a;
            sum_b_in         = acc_b;
            res_valid        = byte_accept;
            res.payload_byte = rx_byte;
            res.byte_index   = count_ff;
            count_in         = count_next;
            if (count_next >= len_ff) begin
               phase_in = PH_CHK1;
            end
         end
         PH_CHK1: begin
            chk1_in  = rx_byte;
            phase_in = PH_CHK2;
         end
         PH_CHK2: begin
            res_valid = byte_accept;
            res.kind  = good ? KIND_GOOD : KIND_BAD;
            count_in  = 8'd0;
            phase_in  = PH_SYNC1;
         end
         default: begin
            // Hunt for the first sync byte; sums restart from it
            phase_in = PH_SYNC1;
            if (rx_byte == cfg.sync_first) begin
               sum_a_in = rx_byte;
               sum_b_in = rx_byte;
               phase_in = PH_SYNC2;
            end
         end
      endcase
   end

   // Update state only on an accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC1;
         desc_ff  <= 8'd0;
         len_ff   <= 8'd0;
         count_ff <= 8'd0;
         sum_a_ff <= 8'd0;
         sum_b_ff <= 8'd0;
         chk1_ff  <= 8'd0;
      end else if (byte_accept) begin
         phase_ff <= phase_in;
         desc_ff  <= desc_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         chk1_ff  <= chk1_in;
      end
   end

   `SFPD_ASSERT(a_verdict_from_chk2, clock, reset,
      (res_valid && res.kind != KIND_PAYLOAD) |-> (phase_ff == PH_CHK2),
      "verdict formed outside the second checksum phase")
   `SFPD_ASSERT(a_index_below_length, clock, reset,
      (res_valid && res.kind == KIND_PAYLOAD) |-> (res.byte_index < res.payload_length),
      "payload index at or beyond declared length")
   `SFPD_ASSERT(a_hunt_after_verdict, clock, reset,
      (byte_accept && phase_ff == PH_CHK2) |=> (phase_ff == PH_SYNC1 && count_ff == 8'd0),
      "parser did not return to hunting after a verdict")

endmodule

[sv/sync_framed_packet_deframer_top.sv]
// ----------------------------------------------------------------------------
// Sync-framed packet deframer, top level
// Serial byte parser with Fletcher-style checksum and an APB register port.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one received byte per transaction (valid/ready).
//   rsp_* carries payload bytes, tagged with descriptor, index and length,
//   and one good/bad verdict per packet after its second checksum byte.
//   Bytes that produce no result (sync, header, first checksum) are
//   absorbed without a response.
//   The parse state updates in a single register-to-register pass, so each
//   byte depends only on the last. Throughput: one byte per cycle while
//   req_ready is high; each result is registered before it shows on rsp_*.
//   An output register plus one skid entry part the two channels: while
//   the receiver stalls the block keeps taking bytes until one more
//   result is held, and req_ready drops only once the skid entry is full.
//   Reset clears the parser to hunting, restores sync bytes 117 and 101
//   and empties the output stages. No clearing pass is needed.
//   Registers: sync_first at address 0, sync_second at address 4.
// ----------------------------------------------------------------------------
module sync_framed_packet_deframer_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_kind,
   output logic [7:0]                      rsp_descriptor,
   output logic [7:0]                      rsp_payload_byte,
   output logic [7:0]                      rsp_byte_index,
   output logic [7:0]                      rsp_payload_length,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [sfpd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import sfpd_pkg::*;

   `include "sync_framed_packet_deframer_top_macros.svh"

   sfpd_cfg_type    cfg_ff;
   sfpd_result_type res;
   logic            res_valid;
   logic            byte_accept;
   logic            rsp_fire;
   logic            csr_write;

   sfpd_result_type out_ff, out_in;
   logic            out_valid_ff, out_valid_in;
   sfpd_result_type skid_ff, skid_in;
   logic            skid_valid_ff, skid_valid_in;

   // Register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == REG_SYNC_SECOND) ? {24'd0, cfg_ff.sync_second}
                                                     : {24'd0, cfg_ff.sync_first};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first  <= SYNC_FIRST_RESET;
         cfg_ff.sync_second <= SYNC_SECOND_RESET;
      end else if (csr_write) begin
         if (paddr[2] == REG_SYNC_SECOND) begin
            cfg_ff.sync_second <= pwdata[7:0];
         end else begin
            cfg_ff.sync_first <= pwdata[7:0];
         end
      end
   end

   // Handshakes
   assign req_ready   = !skid_valid_ff;
   assign byte_accept = req_valid && req_ready;
   assign rsp_fire    = out_valid_ff && rsp_ready;

   sfpd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .rx_byte     (req_rx_byte),
      .cfg         (cfg_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   // Steer new results into the output register or the skid entry
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || rsp_fire) begin
         out_in       = res;
         out_valid_in = res_valid;
      end else if (res_valid) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_ff.kind;
   assign rsp_descriptor     = out_ff.descriptor;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_byte_index     = out_ff.byte_index;
   assign rsp_payload_length = out_ff.payload_length;

   `SFPD_ASSERT(a_skid_behind_out, clock, reset,
      skid_valid_ff |-> out_valid_ff,
      "skid entry holds a result while the output register is empty")
   `SFPD_ASSERT(a_skid_fill_on_stall, clock, reset,
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_ready),
      "skid entry filled without a receiver stall")
   `SFPD_ASSERT(a_verdict_fields_zero, clock, reset,
      (out_valid_ff && out_ff.kind != KIND_PAYLOAD) |->
         (out_ff.payload_byte == 8'd0 && out_ff.byte_index == 8'd0),
      "verdict carries nonzero payload byte or index")

endmodule
